/* sv/csbc_pkg.sv */
`timescale 1ns / 1ps

package csbc_pkg;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_USCR  = 8'h5f;

  localparam logic [2:0] KW_LEN = 3'd6;

  typedef enum logic [6:0] {
    MODE_CODE  = 7'b0000001,
    MODE_LINE  = 7'b0000010,
    MODE_BLOCK = 7'b0000100,
    MODE_STR   = 7'b0001000,
    MODE_CHR   = 7'b0010000,
    MODE_DIR   = 7'b0100000,
    MODE_KW    = 7'b1000000
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  // letters of "define"
  function automatic logic [7:0] kw_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h64;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h66;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h6e;
      3'd5:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39], CH_USCR};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB};
  endfunction

  function automatic res_t mk_res(input logic [7:0] d, input logic code, input logic lst);
    res_t r;
    r.data    = d;
    r.is_code = code;
    r.last    = lst;
    return r;
  endfunction

endpackage

/* sv/csbc_in_if.sv */
`timescale 1ns / 1ps

interface csbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/csbc_out_if.sv */
`timescale 1ns / 1ps

interface csbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_is_code;
  logic       out_last;

  modport source (output valid, output out_byte, output out_is_code, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_is_code, input out_last,
                output ready);
endinterface

/* sv/c_source_code_byte_classifier.sv */
`timescale 1ns / 1ps

// channel  dir  payload                            handshake
// in_ch    in   in_byte[7:0], in_last              valid / ready
// out_ch   out  out_byte[7:0], out_is_code, out_last  valid / ready
//
// one input beat per cycle while in_ch.ready is high; a flag enters the result queue on its byte's beat
// a held slash gives no flag on its own beat and two flags on the next
// in_ch.ready drops while the result queue has fewer than two free entries
// synchronous active-low reset clears lexer state and empties the queue

module c_source_code_byte_classifier #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  csbc_in_if.sink    in_ch,
  csbc_out_if.source out_ch
);
  import csbc_pkg::*;

  push_t push;
  res_t  head;
  logic  head_valid;
  logic  room;
  logic  beat_in;
  logic  beat_out;

  assign beat_in     = in_ch.valid && in_ch.ready;
  assign beat_out    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = room;

  csbc_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (beat_in),
    .data_i  (in_ch.in_byte),
    .last_i  (in_ch.in_last),
    .push_o  (push)
  );

  csbc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .pop_i   (beat_out),
    .res_o   (head),
    .valid_o (head_valid),
    .room_o  (room)
  );

  assign out_ch.valid       = head_valid;
  assign out_ch.out_byte    = head.data;
  assign out_ch.out_is_code = head.is_code;
  assign out_ch.out_last    = head.last;

endmodule

/* sv/csbc_lexer.sv */
`timescale 1ns / 1ps

module csbc_lexer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat_en,
  input  logic [7:0]       data_i,
  input  logic             last_i,
  output csbc_pkg::push_t  push_o
);
  import csbc_pkg::*;

  lex_mode_t  mode_r, mode_nxt;
  logic       crm_r, crm_nxt;
  logic       ls_r, ls_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       slash_r, slash_nxt;
  logic [2:0] kw_r, kw_nxt;
  logic       esc_r, esc_nxt;

  res_t       res [2];
  logic [1:0] n;
  logic       do_code;
  logic       do_dir;

  always_comb begin
    mode_nxt  = mode_r;
    crm_nxt   = crm_r;
    ls_nxt    = ls_r;
    prev_nxt  = data_i;
    slash_nxt = slash_r;
    kw_nxt    = kw_r;
    esc_nxt   = esc_r;
    res[0]    = '0;
    res[1]    = '0;
    n         = 2'd0;
    do_code   = 1'b0;
    do_dir    = 1'b0;

    case (mode_r)
      MODE_LINE: begin
        if (data_i == CH_NL && prev_r != CH_BSL) begin
          mode_nxt = MODE_CODE;
          ls_nxt   = 1'b1;
        end
        res[0] = mk_res(data_i, 1'b0, last_i);
        n      = 2'd1;
      end
      MODE_BLOCK: begin
        if (esc_r && data_i == CH_SLASH) begin
          mode_nxt = crm_r ? MODE_DIR : MODE_CODE;
          esc_nxt  = 1'b0;
          prev_nxt = 8'h00;
        end else begin
          esc_nxt = (data_i == CH_STAR);
        end
        res[0] = mk_res(data_i, 1'b0, last_i);
        n      = 2'd1;
      end
      MODE_STR, MODE_CHR: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (data_i == CH_BSL) begin
          esc_nxt = 1'b1;
        end else if (data_i == ((mode_r == MODE_STR) ? CH_DQUOT : CH_SQUOT)) begin
          mode_nxt = MODE_CODE;
        end
        res[0] = mk_res(data_i, 1'b0, last_i);
        n      = 2'd1;
      end
      MODE_DIR: begin
        do_dir = 1'b1;
        res[0] = mk_res(data_i, 1'b0, last_i);
        n      = 2'd1;
      end
      MODE_KW: begin
        if (kw_r == 3'd0 && is_blank(data_i)) begin
          res[0] = mk_res(data_i, 1'b0, last_i);
          n      = 2'd1;
        end else if (kw_r < KW_LEN && data_i == kw_char(kw_r)) begin
          kw_nxt = kw_r + 3'd1;
          res[0] = mk_res(data_i, 1'b0, last_i);
          n      = 2'd1;
        end else if (kw_r >= KW_LEN && !is_ident(data_i)) begin
          mode_nxt = MODE_CODE;
          kw_nxt   = 3'd0;
          ls_nxt   = 1'b0;
          do_code  = 1'b1;
        end else begin
          mode_nxt = MODE_DIR;
          kw_nxt   = 3'd0;
          do_dir   = 1'b1;
          res[0]   = mk_res(data_i, 1'b0, last_i);
          n        = 2'd1;
        end
      end
      default: begin
        mode_nxt = MODE_CODE;
        if (slash_r) begin
          slash_nxt = 1'b0;
          if (data_i == CH_SLASH) begin
            res[0]   = mk_res(CH_SLASH, 1'b0, 1'b0);
            res[1]   = mk_res(data_i, 1'b0, last_i);
            n        = 2'd2;
            mode_nxt = MODE_LINE;
          end else if (data_i == CH_STAR) begin
            res[0]   = mk_res(CH_SLASH, 1'b0, 1'b0);
            res[1]   = mk_res(data_i, 1'b0, last_i);
            n        = 2'd2;
            mode_nxt = MODE_BLOCK;
            crm_nxt  = 1'b0;
            esc_nxt  = 1'b0;
          end else begin
            ls_nxt  = 1'b0;
            res[0]  = mk_res(CH_SLASH, 1'b1, 1'b0);
            n       = 2'd1;
            do_code = 1'b1;
          end
        end else begin
          do_code = 1'b1;
        end
      end
    endcase

    if (do_dir) begin
      if (data_i == CH_STAR && prev_r == CH_SLASH) begin
        crm_nxt  = 1'b1;
        esc_nxt  = 1'b0;
        mode_nxt = MODE_BLOCK;
      end else if (data_i == CH_NL && prev_r != CH_BSL) begin
        mode_nxt = MODE_CODE;
        ls_nxt   = 1'b1;
      end
    end

    if (do_code) begin
      if (ls_nxt && data_i == CH_HASH) begin
        mode_nxt  = MODE_KW;
        kw_nxt    = 3'd0;
        res[n[0]] = mk_res(data_i, 1'b0, last_i);
        n         = n + 2'd1;
      end else if (data_i == CH_SLASH) begin
        if (!last_i) begin
          slash_nxt = 1'b1;
        end else begin
          ls_nxt    = 1'b0;
          res[n[0]] = mk_res(data_i, 1'b1, last_i);
          n         = n + 2'd1;
        end
      end else if (data_i inside {CH_DQUOT, CH_SQUOT}) begin
        mode_nxt  = (data_i == CH_DQUOT) ? MODE_STR : MODE_CHR;
        esc_nxt   = 1'b0;
        res[n[0]] = mk_res(data_i, 1'b0, last_i);
        n         = n + 2'd1;
      end else if (data_i == CH_NL) begin
        ls_nxt    = 1'b1;
        res[n[0]] = mk_res(data_i, 1'b0, last_i);
        n         = n + 2'd1;
      end else begin
        if (!(data_i inside {CH_SPACE, CH_TAB, CH_CR})) begin
          ls_nxt = 1'b0;
        end
        res[n[0]] = mk_res(data_i, 1'b1, last_i);
        n         = n + 2'd1;
      end
    end

    // end of text: back to the start-of-text state
    if (last_i) begin
      mode_nxt  = MODE_CODE;
      crm_nxt   = 1'b0;
      ls_nxt    = 1'b1;
      prev_nxt  = 8'h00;
      slash_nxt = 1'b0;
      kw_nxt    = 3'd0;
      esc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CODE;
      crm_r   <= 1'b0;
      ls_r    <= 1'b1;
      prev_r  <= 8'h00;
      slash_r <= 1'b0;
      kw_r    <= 3'd0;
      esc_r   <= 1'b0;
    end else if (beat_en) begin
      mode_r  <= mode_nxt;
      crm_r   <= crm_nxt;
      ls_r    <= ls_nxt;
      prev_r  <= prev_nxt;
      slash_r <= slash_nxt;
      kw_r    <= kw_nxt;
      esc_r   <= esc_nxt;
    end
  end

  assign push_o.cnt  = beat_en ? n : 2'd0;
  assign push_o.res0 = res[0];
  assign push_o.res1 = res[1];

  a_slash_in_code: assert property (@(posedge clk) disable iff (!rst_n)
    slash_r |-> mode_r == MODE_CODE)
    else $error("held slash outside code mode");

  a_kw_range: assert property (@(posedge clk) disable iff (!rst_n)
    kw_r <= KW_LEN)
    else $error("keyword position out of range");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    beat_en && last_i |=> mode_r == MODE_CODE && ls_r && !slash_r && kw_r == 3'd0)
    else $error("state not cleared after final byte");

  a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    beat_en && last_i |-> push_o.cnt != 2'd0)
    else $error("final byte produced no result");

endmodule

/* sv/csbc_fifo.sv */
`timescale 1ns / 1ps

module csbc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  csbc_pkg::push_t  push_i,
  input  logic             pop_i,
  output csbc_pkg::res_t   res_o,
  output logic             valid_o,
  output logic             room_o
);
  import csbc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr1;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr1 = inc(wr_ptr_r);

  always_comb begin
    case (push_i.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop_i ? inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push_i.cnt) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_ptr1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign res_o   = mem[rd_ptr_r];
  assign valid_o = (count_r != '0);
  assign room_o  = (count_r <= CNT_W'(DEPTH - 2));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.cnt != 2'd0 |-> count_r <= CNT_W'(DEPTH - 2))
    else $error("push without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(!rst_n) |-> count_r ==
      $past(count_r) + CNT_W'($past(push_i.cnt)) - CNT_W'($past(pop_i)))
    else $error("count out of step with beats");

endmodule
